// File: rtl/core/pfp_pkg.sv
// ============================================================================
// PPS frame parser package
// Shared types, status codes, command and status structs, and the Fi/Di
// tables used to derive the elementary time unit of a parsed PPS request.
// ============================================================================
package pfp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PPS0  = 3'd1,
    PH_PPS1  = 3'd2,
    PH_PPS2  = 3'd3,
    PH_PPS3  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADHDR   = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  localparam logic [7:0] HEADER_RESET = 8'hFF;

  // Option flag masks for PPS1, PPS2 and PPS3.
  localparam logic [2:0] OPT_PPS1 = 3'b001;
  localparam logic [2:0] OPT_PPS2 = 3'b010;
  localparam logic [2:0] OPT_PPS3 = 3'b100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear;      // return all frame state to idle values
    logic       load_hdr;   // header accepted: seed check and count
    logic       accum;      // fold the byte into the check and count it
    logic       load_pps0;  // capture protocol nibble and option flags
    logic       load_pps1;  // capture Fi and Di codes
    logic [2:0] drop_flag;  // option flags to clear
    logic       emit;       // load the result register
    status_e    emit_st;    // status of the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       hdr_match;  // byte equals the header register
    logic       check_zero; // running check folded with this byte is zero
    logic [2:0] flags;      // option flags still pending
    logic [2:0] pps0_flags; // option flags announced by this byte
  } sts_t;

  typedef logic [11:0] fi_tab_t [16];
  typedef logic [7:0]  div_tab_t [16];

  localparam fi_tab_t FI_TABLE = '{
    12'd372, 12'd372, 12'd558, 12'd744, 12'd1116, 12'd1488, 12'd1860, 12'd0,
    12'd0, 12'd512, 12'd768, 12'd1024, 12'd1536, 12'd2048, 12'd0, 12'd0
  };

  // Fi divided by 12 and by 20, truncated.
  localparam div_tab_t FI_DIV12 = '{
    8'd31, 8'd31, 8'd46, 8'd62, 8'd93, 8'd124, 8'd155, 8'd0,
    8'd0, 8'd42, 8'd64, 8'd85, 8'd128, 8'd170, 8'd0, 8'd0
  };

  localparam div_tab_t FI_DIV20 = '{
    8'd18, 8'd18, 8'd27, 8'd37, 8'd55, 8'd74, 8'd93, 8'd0,
    8'd0, 8'd25, 8'd38, 8'd51, 8'd76, 8'd102, 8'd0, 8'd0
  };

  // True when both codes map to defined table values.
  function automatic logic etu_defined(input logic [3:0] fi, input logic [3:0] di);
    logic fi_ok;
    logic di_ok;
    fi_ok = (FI_TABLE[fi] != 12'd0);
    di_ok = (di >= 4'd1) && (di <= 4'd9);
    return fi_ok && di_ok;
  endfunction

  // Fi/Di. Di codes 1 to 7 are powers of two, codes 8 and 9 are 12 and 20.
  function automatic logic [11:0] etu_calc(input logic [3:0] fi, input logic [3:0] di);
    logic [11:0] res;
    res = 12'd0;
    if (etu_defined(fi, di)) begin
      case (di)
        4'd8:    res = {4'd0, FI_DIV12[fi]};
        4'd9:    res = {4'd0, FI_DIV20[fi]};
        default: res = FI_TABLE[fi] >> (di - 4'd1);
      endcase
    end
    return res;
  endfunction

  // First phase still announced by the option flags, else the check byte.
  function automatic phase_e next_phase(input logic [2:0] flags);
    phase_e ph;
    if (flags[0]) begin
      ph = PH_PPS1;
    end else if (flags[1]) begin
      ph = PH_PPS2;
    end else if (flags[2]) begin
      ph = PH_PPS3;
    end else begin
      ph = PH_CHECK;
    end
    return ph;
  endfunction

endpackage

// File: rtl/core/pfp_ctrl.sv
// ============================================================================
// PPS frame parser controller
// Tracks the frame phase, issues datapath commands for each accepted item
// and owns the result valid flag.
// ============================================================================
module pfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          frame_start_i,
  input  logic          buffer_end_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  pfp_pkg::sts_t sts_i,
  output pfp_pkg::cmd_t cmd_o
);

  pfp_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic [2:0]      flags_nxt;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pfp_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cmd_o     = '0;
    flags_nxt = sts_i.flags;
    if (accept) begin
      if (frame_start_i) begin
        cmd_o.clear = 1'b1;
        phase_d     = pfp_pkg::PH_IDLE;
        if (!sts_i.hdr_match) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_st = pfp_pkg::ST_BADHDR;
        end else if (buffer_end_i) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_st = pfp_pkg::ST_TRUNC;
        end else begin
          cmd_o.load_hdr = 1'b1;
          phase_d        = pfp_pkg::PH_PPS0;
        end
      end else begin
        case (phase_q)
          pfp_pkg::PH_IDLE: begin
            phase_d = pfp_pkg::PH_IDLE;
          end
          pfp_pkg::PH_CHECK: begin
            cmd_o.accum   = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.emit_st = sts_i.check_zero ? pfp_pkg::ST_OK : pfp_pkg::ST_MISMATCH;
            cmd_o.clear   = 1'b1;
            phase_d       = pfp_pkg::PH_IDLE;
          end
          pfp_pkg::PH_PPS0, pfp_pkg::PH_PPS1, pfp_pkg::PH_PPS2, pfp_pkg::PH_PPS3: begin
            cmd_o.accum = 1'b1;
            case (phase_q)
              pfp_pkg::PH_PPS0: begin
                cmd_o.load_pps0 = 1'b1;
                flags_nxt       = sts_i.pps0_flags;
              end
              pfp_pkg::PH_PPS1: begin
                cmd_o.load_pps1 = 1'b1;
                cmd_o.drop_flag = pfp_pkg::OPT_PPS1;
              end
              pfp_pkg::PH_PPS2: begin
                cmd_o.drop_flag = pfp_pkg::OPT_PPS2;
              end
              default: begin
                cmd_o.drop_flag = pfp_pkg::OPT_PPS3;
              end
            endcase
            if (!cmd_o.load_pps0) begin
              flags_nxt = sts_i.flags & ~cmd_o.drop_flag;
            end
            if (buffer_end_i) begin
              cmd_o.emit    = 1'b1;
              cmd_o.emit_st = pfp_pkg::ST_TRUNC;
              cmd_o.clear   = 1'b1;
              phase_d       = pfp_pkg::PH_IDLE;
            end else begin
              phase_d = pfp_pkg::next_phase(flags_nxt);
            end
          end
          default: begin
            phase_d = pfp_pkg::PH_IDLE;
          end
        endcase
      end
    end
    out_valid_d = (out_valid_q & out_stall_i) | cmd_o.emit;
  end

endmodule

// File: rtl/core/pfp_datapath.sv
// ============================================================================
// PPS frame parser datapath
// Holds the header register, running check, option flags, captured PPS
// fields and the result register.
// ============================================================================
module pfp_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic [7:0]    data_byte_i,
  input  pfp_pkg::cmd_t cmd_i,
  output pfp_pkg::sts_t sts_o,
  output logic [1:0]    status_o,
  output logic [2:0]    frame_length_o,
  output logic [3:0]    protocol_o,
  output logic          pps1_present_o,
  output logic [3:0]    fi_code_o,
  output logic [3:0]    di_code_o,
  output logic [11:0]   etu_o,
  output logic          etu_valid_o
);

  logic [7:0]  header_q;
  logic [7:0]  acc_q, acc_d;
  logic [2:0]  flags_q, flags_d;
  logic [3:0]  fi_q, fi_d;
  logic [3:0]  di_q, di_d;
  logic        have_q, have_d;
  logic [2:0]  count_q, count_d;
  logic [3:0]  proto_q, proto_d;

  logic [1:0]  status_q;
  logic [2:0]  length_q;
  logic [3:0]  proto_out_q;
  logic        pps1_q;
  logic [3:0]  fi_out_q;
  logic [3:0]  di_out_q;
  logic [11:0] etu_q;
  logic        etu_ok_q;
  logic        frame_ok;

  assign sts_o.hdr_match  = (data_byte_i == header_q);
  assign sts_o.check_zero = ((acc_q ^ data_byte_i) == 8'd0);
  assign sts_o.flags      = flags_q;
  assign sts_o.pps0_flags = data_byte_i[6:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= pfp_pkg::HEADER_RESET;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    acc_d   = acc_q;
    flags_d = flags_q;
    fi_d    = fi_q;
    di_d    = di_q;
    have_d  = have_q;
    count_d = count_q;
    proto_d = proto_q;
    if (cmd_i.accum) begin
      acc_d   = acc_q ^ data_byte_i;
      count_d = count_q + 3'd1;
    end
    if (cmd_i.load_pps0) begin
      proto_d = data_byte_i[3:0];
      flags_d = data_byte_i[6:4];
    end
    if (cmd_i.load_pps1) begin
      fi_d   = data_byte_i[7:4];
      di_d   = data_byte_i[3:0];
      have_d = 1'b1;
    end
    flags_d = flags_d & ~cmd_i.drop_flag;
    if (cmd_i.clear) begin
      acc_d   = 8'd0;
      flags_d = 3'd0;
      fi_d    = 4'd0;
      di_d    = 4'd0;
      have_d  = 1'b0;
      count_d = 3'd0;
      proto_d = 4'd0;
    end
    if (cmd_i.load_hdr) begin
      acc_d   = data_byte_i;
      count_d = 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 8'd0;
      flags_q <= 3'd0;
      fi_q    <= 4'd0;
      di_q    <= 4'd0;
      have_q  <= 1'b0;
      count_q <= 3'd0;
      proto_q <= 4'd0;
    end else begin
      acc_q   <= acc_d;
      flags_q <= flags_d;
      fi_q    <= fi_d;
      di_q    <= di_d;
      have_q  <= have_d;
      count_q <= count_d;
      proto_q <= proto_d;
    end
  end

  // Only a clean frame carries fields; an error result zeroes all but status.
  assign frame_ok = (cmd_i.emit_st == pfp_pkg::ST_OK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q    <= cmd_i.emit_st;
      length_q    <= frame_ok ? count_q + 3'd1 : 3'd0;
      proto_out_q <= frame_ok ? proto_q : 4'd0;
      pps1_q      <= frame_ok & have_q;
      fi_out_q    <= (frame_ok & have_q) ? fi_q : 4'd0;
      di_out_q    <= (frame_ok & have_q) ? di_q : 4'd0;
      etu_q       <= (frame_ok & have_q) ? pfp_pkg::etu_calc(fi_q, di_q) : 12'd0;
      etu_ok_q    <= frame_ok & have_q & pfp_pkg::etu_defined(fi_q, di_q);
    end
  end

  assign status_o       = status_q;
  assign frame_length_o = length_q;
  assign protocol_o     = proto_out_q;
  assign pps1_present_o = pps1_q;
  assign fi_code_o      = fi_out_q;
  assign di_code_o      = di_out_q;
  assign etu_o          = etu_q;
  assign etu_valid_o    = etu_ok_q;

endmodule

// File: rtl/core/pps_frame_parser.sv
// ============================================================================
// PPS frame parser
// Parses smartcard protocol and parameter selection requests byte by byte.
// ============================================================================
// The parser takes one received byte per cycle and returns one result per
// finished frame, held in an output register so that the next byte is taken
// while a result still waits; a byte is stalled only while a result is held
// and the consumer stalls. A byte flagged as frame start opens a frame and
// must equal the header register, which resets to 0xFF and is written through
// the cfg_we_i/cfg_wdata_i port; the user must write it only while no frame is
// in progress, which the block does not enforce. The PPS0 byte that follows
// gives the protocol in its low nibble and announces PPS1, PPS2 and PPS3 in
// bits 4 to 6; bit 7 is ignored. The frame ends with a check byte that must
// bring the XOR of all frame bytes to zero. The status of a result is ok, bad
// header, truncated (the buffer ended before the check byte) or check mismatch;
// on any status other than ok all other fields are zero. When PPS1 was present
// its Fi and Di codes are reported, and the ETU is Fi/Di from the standard
// tables, with etu_valid low for reserved codes. Bytes seen outside a frame are
// dropped, and a new frame start abandons an open frame without a result.
module pps_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  frame_length_o,
  output logic [3:0]  protocol_o,
  output logic        pps1_present_o,
  output logic [3:0]  fi_code_o,
  output logic [3:0]  di_code_o,
  output logic [11:0] etu_o,
  output logic        etu_valid_o
);

  pfp_pkg::cmd_t cmd;
  pfp_pkg::sts_t sts;

  pfp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_start_i (frame_start_i),
    .buffer_end_i  (buffer_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pfp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .protocol_o     (protocol_o),
    .pps1_present_o (pps1_present_o),
    .fi_code_o      (fi_code_o),
    .di_code_o      (di_code_o),
    .etu_o          (etu_o),
    .etu_valid_o    (etu_valid_o)
  );

endmodule
